// File: sv/pmi_pkg.sv
// Shared types and constants for the polygon moment of inertia core.
// No dependencies; every other file imports this package.
package pmi_pkg;

  localparam int VERTEX_W         = 12;
  localparam int MASS_W           = 24;
  localparam int INERTIA_W        = 48;
  localparam int CEN_W            = 20;
  localparam int STATUS_W         = 2;
  localparam int AREA_W           = 32;
  localparam int CSUM_W           = 45;
  localparam int MSUM_W           = 57;
  localparam int WIDE_W           = 128;
  localparam int DIVISOR_W        = 64;
  localparam int FIFO_DEPTH       = 2;
  localparam int MAX_VERTICES_DEF = 64;
  localparam int COORD_BITS_DEF   = 12;

  localparam logic [MASS_W-1:0]       MASS_RESET = MASS_W'(256);
  localparam logic signed [CEN_W-1:0] CEN_MAX    = {1'b0, {(CEN_W-1){1'b1}}};
  localparam logic signed [CEN_W-1:0] CEN_MIN    = {1'b1, {(CEN_W-1){1'b0}}};

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_ZERO_AREA = 2'd1,
    ST_OVERFLOW  = 2'd2
  } status_e;

  typedef enum logic {
    MD_MUL,
    MD_DIV
  } md_op_e;

  typedef struct packed {
    logic   start;
    md_op_e op;
  } md_req_t;

  typedef struct packed {
    logic [VERTEX_W-1:0] x;
    logic [VERTEX_W-1:0] y;
    logic                last;
    logic                first;
    logic                drop;
    logic                ovf;
  } vtx_entry_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_E1,
    B_E2,
    B_E3,
    B_E4,
    B_FIN,
    B_ISSUE,
    B_WAIT,
    B_OUT
  } back_state_e;

  typedef enum logic [2:0] {
    S_P,
    S_SX,
    S_SY,
    S_M,
    S_D1,
    S_D2,
    S_CX,
    S_CY
  } step_e;

endpackage

// File: sv/polygon_moment_of_inertia_core.sv
// Polygon moment of inertia core: an edge pipeline runs for each vertex after
// the first (the last one also runs its closing edge) behind a two-entry
// queue; start is taken every cycle until the queue fills. A final sequence on
// the multiply/divide unit follows each polygon (skipped on a fault status),
// one strobe each. Results cannot be stalled. Asynchronous active-low reset
// clears all sums; body_mass resets to 1.0.
module polygon_moment_of_inertia_core #(
  parameter int MAX_VERTICES = pmi_pkg::MAX_VERTICES_DEF,
  parameter int COORD_BITS   = pmi_pkg::COORD_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [pmi_pkg::VERTEX_W-1:0] vertex_x_i,
  input  logic signed [pmi_pkg::VERTEX_W-1:0] vertex_y_i,
  input  logic                                last_vertex_i,
  input  logic                                body_mass_we_i,
  input  logic [pmi_pkg::MASS_W-1:0]          body_mass_wdata_i,
  output logic                                result_valid_o,
  output logic [pmi_pkg::INERTIA_W-1:0]       inertia_o,
  output logic signed [pmi_pkg::CEN_W-1:0]    centroid_x_o,
  output logic signed [pmi_pkg::CEN_W-1:0]    centroid_y_o,
  output logic [pmi_pkg::STATUS_W-1:0]        status_o
);
  import pmi_pkg::*;

  logic [MASS_W-1:0] mass_q;
  logic              full, push, pop, fvalid, md_done;
  vtx_entry_t        push_entry, head_entry;
  md_req_t           md_req;
  logic [WIDE_W-1:0]    md_a, md_result;
  logic [DIVISOR_W-1:0] md_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mass_q <= MASS_RESET;
    end else if (body_mass_we_i) begin
      mass_q <= body_mass_wdata_i;
    end
  end

  pmi_front #(.MAX_VERTICES(MAX_VERTICES)) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .full_i        (full),
    .vertex_x_i    (vertex_x_i),
    .vertex_y_i    (vertex_y_i),
    .last_vertex_i (last_vertex_i),
    .busy_o        (busy),
    .push_o        (push),
    .entry_o       (push_entry)
  );

  pmi_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .full_o  (full),
    .valid_o (fvalid),
    .entry_o (head_entry)
  );

  pmi_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (fvalid),
    .entry_i        (head_entry),
    .pop_o          (pop),
    .mass_i         (mass_q),
    .md_req_o       (md_req),
    .md_a_o         (md_a),
    .md_b_o         (md_b),
    .md_done_i      (md_done),
    .md_result_i    (md_result),
    .result_valid_o (result_valid_o),
    .inertia_o      (inertia_o),
    .centroid_x_o   (centroid_x_o),
    .centroid_y_o   (centroid_y_o),
    .status_o       (status_o)
  );

  pmi_muldiv u_muldiv (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (md_req),
    .a_i      (md_a),
    .b_i      (md_b),
    .done_o   (md_done),
    .result_o (md_result)
  );

endmodule

// File: sv/pmi_front.sv
// Front end: accepts vertices, counts them and classifies each one.
// Depends on pmi_pkg.
module pmi_front #(
  parameter int MAX_VERTICES = pmi_pkg::MAX_VERTICES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic                          full_i,
  input  logic [pmi_pkg::VERTEX_W-1:0]  vertex_x_i,
  input  logic [pmi_pkg::VERTEX_W-1:0]  vertex_y_i,
  input  logic                          last_vertex_i,
  output logic                          busy_o,
  output logic                          push_o,
  output pmi_pkg::vtx_entry_t           entry_o
);
  import pmi_pkg::*;

  localparam int CNT_W = $clog2(MAX_VERTICES + 1);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             ovf_q, ovf_d;
  logic             accept, dropped;

  assign busy_o  = full_i;
  assign accept  = start_i & ~full_i;
  assign dropped = (cnt_q == CNT_W'(MAX_VERTICES));
  assign push_o  = accept & (~dropped | last_vertex_i);

  always_comb begin
    entry_o.x     = vertex_x_i;
    entry_o.y     = vertex_y_i;
    entry_o.last  = last_vertex_i;
    entry_o.first = (cnt_q == '0);
    entry_o.drop  = dropped;
    entry_o.ovf   = ovf_q | dropped;
  end

  always_comb begin
    cnt_d = cnt_q;
    ovf_d = ovf_q;
    if (accept) begin
      if (last_vertex_i) begin
        cnt_d = '0;
        ovf_d = 1'b0;
      end else if (dropped) begin
        ovf_d = 1'b1;
      end else begin
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      ovf_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      ovf_q <= ovf_d;
    end
  end

endmodule

// File: sv/pmi_fifo.sv
// Short queue of classified vertices between front and back end.
// Depends on pmi_pkg.
module pmi_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  pmi_pkg::vtx_entry_t entry_i,
  input  logic                pop_i,
  output logic                full_o,
  output logic                valid_o,
  output pmi_pkg::vtx_entry_t entry_o
);
  import pmi_pkg::*;

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  vtx_entry_t       mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(FIFO_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign entry_o = mem_q[rd_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_q + CNT_W'(do_push) - CNT_W'(do_pop);
    end
  end

endmodule

// File: sv/pmi_muldiv.sv
// Iterative unit: shift-add multiply and restoring divide, one bit per cycle.
// Depends on pmi_pkg.
module pmi_muldiv (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  pmi_pkg::md_req_t                 req_i,
  input  logic [pmi_pkg::WIDE_W-1:0]       a_i,
  input  logic [pmi_pkg::DIVISOR_W-1:0]    b_i,
  output logic                             done_o,
  output logic [pmi_pkg::WIDE_W-1:0]       result_o
);
  import pmi_pkg::*;

  localparam int CNT_W = $clog2(WIDE_W);

  logic                 busy_q, done_q;
  md_op_e               op_q;
  logic [WIDE_W-1:0]    a_q, acc_q;
  logic [DIVISOR_W-1:0] b_q;
  logic [DIVISOR_W:0]   rem_q, rem_sh;
  logic [CNT_W-1:0]     cnt_q;
  logic                 fits;

  assign rem_sh   = {rem_q[DIVISOR_W-1:0], a_q[WIDE_W-1]};
  assign fits     = (rem_sh >= {1'b0, b_q});
  assign done_o   = done_q;
  assign result_o = (op_q == MD_MUL) ? acc_q : a_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= MD_MUL;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        op_q   <= req_i.op;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (op_q == MD_MUL) begin
          if (b_q == '0) begin
            busy_q <= 1'b0;
            done_q <= 1'b1;
          end
        end else begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CNT_W'(WIDE_W - 1)) begin
            busy_q <= 1'b0;
            done_q <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
      rem_q <= '0;
    end else if (busy_q) begin
      if (op_q == MD_MUL) begin
        if (b_q != '0) begin
          if (b_q[0]) begin
            acc_q <= acc_q + a_q;
          end
          a_q <= {a_q[WIDE_W-2:0], 1'b0};
          b_q <= {1'b0, b_q[DIVISOR_W-1:1]};
        end
      end else begin
        rem_q <= fits ? rem_sh - {1'b0, b_q} : rem_sh;
        a_q   <= {a_q[WIDE_W-2:0], fits};
      end
    end
  end

endmodule

// File: sv/pmi_back.sv
// Back end: per-edge shoelace accumulation and final inertia and centroid sequence.
// Depends on pmi_pkg; drives the pmi_muldiv unit for every step of that sequence.
module pmi_back #(
  parameter int COORD_BITS = pmi_pkg::COORD_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 valid_i,
  input  pmi_pkg::vtx_entry_t                  entry_i,
  output logic                                 pop_o,
  input  logic [pmi_pkg::MASS_W-1:0]           mass_i,
  output pmi_pkg::md_req_t                     md_req_o,
  output logic [pmi_pkg::WIDE_W-1:0]           md_a_o,
  output logic [pmi_pkg::DIVISOR_W-1:0]        md_b_o,
  input  logic                                 md_done_i,
  input  logic [pmi_pkg::WIDE_W-1:0]           md_result_i,
  output logic                                 result_valid_o,
  output logic [pmi_pkg::INERTIA_W-1:0]        inertia_o,
  output logic signed [pmi_pkg::CEN_W-1:0]     centroid_x_o,
  output logic signed [pmi_pkg::CEN_W-1:0]     centroid_y_o,
  output logic [pmi_pkg::STATUS_W-1:0]         status_o
);
  import pmi_pkg::*;

  localparam int CB  = COORD_BITS;
  localparam int PW  = 2 * CB;
  localparam int CRW = 2 * CB + 1;
  localparam int SQW = 2 * CB + 3;
  localparam int SXW = CB + 1;

  back_state_e state_q, state_d;
  step_e       step_q;

  logic signed [CB-1:0]  px_q, py_q, qx_q, qy_q;
  logic signed [CB-1:0]  fx_q, fy_q, vx_q, vy_q, cx, cy;
  logic                  last_q, close_q, ovf_q;
  logic signed [PW-1:0]  m_pxqy_q, m_qxpy_q, m_pxpx_q, m_pxqx_q, m_qxqx_q;
  logic signed [PW-1:0]  m_pypy_q, m_pyqy_q, m_qyqy_q;
  logic signed [CRW-1:0] cr_q;
  logic signed [SQW-1:0] sq_q;
  logic signed [SXW-1:0] sx_q, sy_q;
  logic signed [SXW+CRW-1:0] tx_q, ty_q;
  logic signed [SQW+CRW-1:0] tm_q;

  logic signed [AREA_W-1:0] area_q;
  logic signed [CSUM_W-1:0] cxs_q, cys_q;
  logic signed [MSUM_W-1:0] ms_q;

  logic [AREA_W-1:0]  aa_q;
  logic [MSUM_W-1:0]  ma_q;
  logic [CSUM_W-1:0]  mx_q, my_q;
  logic               pos_q, negx_q, negy_q;
  logic [WIDE_W-1:0]  p_q, s_q, dq_q, s_new;
  logic [AREA_W+2:0]  aa6;
  logic [AREA_W+1:0]  aa3;
  logic [AREA_W+4:0]  aa18;

  logic [INERTIA_W-1:0]    inertia_q;
  logic signed [CEN_W-1:0] cenx_q, ceny_q;
  status_e                 status_q;

  assign cx    = signed'(CB'(entry_i.x));
  assign cy    = signed'(CB'(entry_i.y));
  assign aa3   = (AREA_W+2)'(aa_q) + (AREA_W+2)'({aa_q, 1'b0});
  assign aa6   = {aa3, 1'b0};
  assign aa18  = (AREA_W+5)'({aa_q, 4'b0}) + (AREA_W+5)'({aa_q, 1'b0});
  assign s_new = (s_q + md_result_i) << 1;

  function automatic logic signed [CEN_W-1:0] cen_sat(input logic [WIDE_W-1:0] q,
                                                      input logic neg);
    logic signed [CEN_W-1:0] c;
    if (neg) begin
      c = (q > WIDE_W'(CEN_MAX) + WIDE_W'(1)) ? CEN_MIN : CEN_W'(-q);
    end else begin
      c = (q > WIDE_W'(CEN_MAX)) ? CEN_MAX : CEN_W'(q);
    end
    return c;
  endfunction

  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE: begin
        if (valid_i) begin
          if (entry_i.drop) begin
            state_d = B_FIN;
          end else if (entry_i.first) begin
            state_d = entry_i.last ? B_FIN : B_IDLE;
          end else begin
            state_d = B_E1;
          end
        end
      end
      B_E1:    state_d = B_E2;
      B_E2:    state_d = B_E3;
      B_E3:    state_d = B_E4;
      B_E4: begin
        if (close_q) begin
          state_d = B_E1;
        end else begin
          state_d = last_q ? B_FIN : B_IDLE;
        end
      end
      B_FIN:   state_d = (ovf_q || area_q == '0) ? B_OUT : B_ISSUE;
      B_ISSUE: state_d = B_WAIT;
      B_WAIT: begin
        if (md_done_i) begin
          state_d = (step_q == S_CY) ? B_OUT : B_ISSUE;
        end
      end
      B_OUT:   state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  always_comb begin
    pop_o          = (state_q == B_IDLE) & valid_i;
    result_valid_o = (state_q == B_OUT);
    md_req_o.start = (state_q == B_ISSUE);
    md_req_o.op    = MD_DIV;
    md_a_o         = '0;
    md_b_o         = '0;
    case (step_q)
      S_P: begin
        md_req_o.op = MD_MUL;
        md_a_o      = WIDE_W'(ma_q);
        md_b_o      = DIVISOR_W'(aa_q);
      end
      S_SX: begin
        md_req_o.op = MD_MUL;
        md_a_o      = WIDE_W'(mx_q);
        md_b_o      = DIVISOR_W'(mx_q);
      end
      S_SY: begin
        md_req_o.op = MD_MUL;
        md_a_o      = WIDE_W'(my_q);
        md_b_o      = DIVISOR_W'(my_q);
      end
      S_M: begin
        md_req_o.op = MD_MUL;
        md_a_o      = dq_q;
        md_b_o      = DIVISOR_W'(mass_i);
      end
      S_D1: begin
        md_a_o = dq_q;
        md_b_o = DIVISOR_W'(aa_q);
      end
      S_D2: begin
        md_a_o = dq_q;
        md_b_o = DIVISOR_W'(aa18);
      end
      S_CX: begin
        md_a_o = WIDE_W'({mx_q, 1'b0}) + WIDE_W'(aa3);
        md_b_o = DIVISOR_W'(aa6);
      end
      S_CY: begin
        md_a_o = WIDE_W'({my_q, 1'b0}) + WIDE_W'(aa3);
        md_b_o = DIVISOR_W'(aa6);
      end
      default: begin
        md_a_o = '0;
      end
    endcase
  end

  assign inertia_o    = inertia_q;
  assign centroid_x_o = cenx_q;
  assign centroid_y_o = ceny_q;
  assign status_o     = status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      step_q  <= S_P;
      area_q  <= '0;
      cxs_q   <= '0;
      cys_q   <= '0;
      ms_q    <= '0;
      fx_q    <= '0;
      fy_q    <= '0;
      vx_q    <= '0;
      vy_q    <= '0;
      last_q  <= 1'b0;
      close_q <= 1'b0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      case (state_q)
        B_IDLE: begin
          if (valid_i) begin
            last_q  <= entry_i.last;
            ovf_q   <= entry_i.ovf;
            close_q <= entry_i.last & ~entry_i.drop & ~entry_i.first;
            if (!entry_i.drop) begin
              vx_q <= cx;
              vy_q <= cy;
              if (entry_i.first) begin
                fx_q <= cx;
                fy_q <= cy;
              end
            end
          end
        end
        B_E4: begin
          area_q  <= area_q + AREA_W'(cr_q);
          cxs_q   <= cxs_q + CSUM_W'(tx_q);
          cys_q   <= cys_q + CSUM_W'(ty_q);
          ms_q    <= ms_q + MSUM_W'(tm_q);
          close_q <= 1'b0;
        end
        B_FIN: begin
          step_q <= S_P;
        end
        B_WAIT: begin
          if (md_done_i) begin
            case (step_q)
              S_P:  step_q <= S_SX;
              S_SX: step_q <= S_SY;
              S_SY: step_q <= (pos_q && s_new < p_q) ? S_M : S_CX;
              S_M:  step_q <= S_D1;
              S_D1: step_q <= S_D2;
              S_D2: step_q <= S_CX;
              S_CX: step_q <= S_CY;
              default: step_q <= S_P;
            endcase
          end
        end
        B_OUT: begin
          area_q <= '0;
          cxs_q  <= '0;
          cys_q  <= '0;
          ms_q   <= '0;
          fx_q   <= '0;
          fy_q   <= '0;
          vx_q   <= '0;
          vy_q   <= '0;
          ovf_q  <= 1'b0;
          last_q <= 1'b0;
        end
        default: begin
          step_q <= step_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      B_IDLE: begin
        px_q <= vx_q;
        py_q <= vy_q;
        qx_q <= cx;
        qy_q <= cy;
      end
      B_E1: begin
        m_pxqy_q <= px_q * qy_q;
        m_qxpy_q <= qx_q * py_q;
        m_pxpx_q <= px_q * px_q;
        m_pxqx_q <= px_q * qx_q;
        m_qxqx_q <= qx_q * qx_q;
        m_pypy_q <= py_q * py_q;
        m_pyqy_q <= py_q * qy_q;
        m_qyqy_q <= qy_q * qy_q;
      end
      B_E2: begin
        cr_q <= CRW'(m_pxqy_q) - CRW'(m_qxpy_q);
        sq_q <= SQW'(m_pxpx_q) + SQW'(m_pxqx_q) + SQW'(m_qxqx_q)
              + SQW'(m_pypy_q) + SQW'(m_pyqy_q) + SQW'(m_qyqy_q);
        sx_q <= SXW'(px_q) + SXW'(qx_q);
        sy_q <= SXW'(py_q) + SXW'(qy_q);
      end
      B_E3: begin
        tx_q <= sx_q * cr_q;
        ty_q <= sy_q * cr_q;
        tm_q <= sq_q * cr_q;
      end
      B_E4: begin
        px_q <= vx_q;
        py_q <= vy_q;
        qx_q <= fx_q;
        qy_q <= fy_q;
      end
      B_FIN: begin
        aa_q      <= area_q[AREA_W-1] ? AREA_W'(-area_q) : AREA_W'(area_q);
        ma_q      <= ms_q[MSUM_W-1] ? MSUM_W'(-ms_q) : MSUM_W'(ms_q);
        mx_q      <= cxs_q[CSUM_W-1] ? CSUM_W'(-cxs_q) : CSUM_W'(cxs_q);
        my_q      <= cys_q[CSUM_W-1] ? CSUM_W'(-cys_q) : CSUM_W'(cys_q);
        pos_q     <= (ms_q != '0) && (ms_q[MSUM_W-1] == area_q[AREA_W-1]);
        negx_q    <= cxs_q[CSUM_W-1] != area_q[AREA_W-1];
        negy_q    <= cys_q[CSUM_W-1] != area_q[AREA_W-1];
        inertia_q <= '0;
        cenx_q    <= '0;
        ceny_q    <= '0;
        if (ovf_q) begin
          status_q <= ST_OVERFLOW;
        end else if (area_q == '0) begin
          status_q <= ST_ZERO_AREA;
        end else begin
          status_q <= ST_OK;
        end
      end
      B_WAIT: begin
        if (md_done_i) begin
          case (step_q)
            S_P:  p_q <= md_result_i + {md_result_i[WIDE_W-2:0], 1'b0};
            S_SX: s_q <= md_result_i;
            S_SY: begin
              s_q  <= s_new;
              dq_q <= p_q - s_new;
            end
            S_M:  dq_q <= md_result_i;
            S_D1: dq_q <= md_result_i;
            S_D2: begin
              inertia_q <= (md_result_i[WIDE_W-1:INERTIA_W] != '0) ?
                           '1 : INERTIA_W'(md_result_i);
            end
            S_CX: cenx_q <= cen_sat(md_result_i, negx_q);
            S_CY: ceny_q <= cen_sat(md_result_i, negy_q);
            default: begin
              dq_q <= dq_q;
            end
          endcase
        end
      end
      default: begin
        px_q <= px_q;
      end
    endcase
  end

endmodule

// File: sv/pmi_checker.sv
// Port-level checks for the polygon moment of inertia core, with bind.
// Depends on pmi_pkg and polygon_moment_of_inertia_core.
module pmi_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                result_valid_o,
  input logic [pmi_pkg::INERTIA_W-1:0]       inertia_o,
  input logic signed [pmi_pkg::CEN_W-1:0]    centroid_x_o,
  input logic signed [pmi_pkg::CEN_W-1:0]    centroid_y_o,
  input logic [pmi_pkg::STATUS_W-1:0]        status_o
);
  import pmi_pkg::*;

  a_status_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (status_o == ST_OK || status_o == ST_ZERO_AREA ||
                        status_o == ST_OVERFLOW))
    else $error("illegal status code");

  a_fault_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && status_o != ST_OK) |->
      (inertia_o == '0 && centroid_x_o == '0 && centroid_y_o == '0))
    else $error("fault result carries nonzero payload");

  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe held for two cycles");

endmodule

bind polygon_moment_of_inertia_core pmi_checker u_pmi_checker (.*);
